### hw/rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg: shared definitions for the line ring with overflow statistics
// Sizes, command codes, sequencer states and the request and response
// structures of the shared add/subtract unit.
// ----------------------------------------------------------------------------
package lrs_pkg;

  // Ring size; a power of two so that pointer differences wrap for free
  localparam int DEPTH     = 1024;
  localparam int MAX_BURST = 16;

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int LEN_W     = $clog2(DEPTH + 1);
  localparam int CNT_W     = $clog2(MAX_BURST + 1);
  localparam int STAT_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int MAX_LEN_W = 5;

  localparam logic [PTR_W-1:0]     PTR_ONE    = PTR_W'(1);
  localparam logic [PTR_W-1:0]     PTR_LAST   = PTR_W'(DEPTH - 1);
  localparam logic [LEN_W-1:0]     LEN_ONE    = LEN_W'(1);
  localparam logic [LEN_W-1:0]     DEPTH_LEN  = LEN_W'(DEPTH);
  localparam logic [CNT_W-1:0]     CNT_ONE    = CNT_W'(1);
  localparam logic [MAX_LEN_W-1:0] BURST_CAP  = MAX_LEN_W'(MAX_BURST);
  localparam logic [STAT_W-1:0]    STAT_ONE   = STAT_W'(1);

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] NUL_BYTE     = 8'h00;

  // Command codes; the fourth code is unused and answers with a status result
  localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END_LINE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_END_PUT,
    S_END_ROOM,
    S_END_MARK,
    S_RD_AVAIL,
    S_RD_SIZE,
    S_RD_BYTES,
    S_RD_BURST,
    S_RD_OUT,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic              sub;
    logic [STAT_W-1:0] a;
    logic [STAT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] res;
    logic              lt;
  } alu_rsp_t;

  // Step a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p == PTR_LAST) ? '0 : p + PTR_ONE;
    return q;
  endfunction

endpackage

### hw/rtl/lrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module lrs_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lrs_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_alu: shared add/subtract unit
// One 32-bit adder used by the sequencer for counter updates, pointer
// differences and the less-than compares; lt is the borrow of a subtract.
// ----------------------------------------------------------------------------
module lrs_alu (
  input  lrs_pkg::alu_req_t req,
  output lrs_pkg::alu_rsp_t rsp
);

  logic [lrs_pkg::STAT_W:0]   sum;
  logic [lrs_pkg::STAT_W-1:0] b_op;

  // Add, or subtract as a + ~b + 1
  always_comb begin
    b_op    = req.sub ? ~req.b : req.b;
    sum     = {1'b0, req.a} + {1'b0, b_op} + {{lrs_pkg::STAT_W{1'b0}}, req.sub};
    rsp.res = sum[lrs_pkg::STAT_W-1:0];
    rsp.lt  = req.sub & ~sum[lrs_pkg::STAT_W];
  end

endmodule

### hw/rtl/line_ring_with_overflow_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_ring_with_overflow_stats: byte ring fed with text lines, read in bursts
// Sequencer around a 1024-byte ring RAM and one shared add/subtract unit.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the last result of that transaction has been shown. Results
// appear for exactly one cycle each, marked by done, and cannot be held off.
// A write byte runs the write and status states, an end line the newline,
// room, watermark and status states, a read the fill, size, byte-count and
// burst states, then its bytes (an empty read: size, then status). The
// single shared 32-bit adder, updating one counter or making one compare per
// cycle, and the one read port of the ring RAM, yielding one byte per cycle,
// set this order. The statistics ports already carry the final values of the
// transaction on its first result. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module line_ring_with_overflow_stats (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  output logic                               done,
  input  logic [lrs_pkg::CMD_W-1:0]          command,
  input  logic [lrs_pkg::BYTE_W-1:0]         line_byte,
  input  logic [lrs_pkg::MAX_LEN_W-1:0]      max_len,
  output logic [lrs_pkg::BYTE_W-1:0]         out_byte,
  output logic                               byte_valid,
  output logic                               last,
  output logic                               try_again,
  output logic [lrs_pkg::STAT_W-1:0]         overflow_count,
  output logic [lrs_pkg::STAT_W-1:0]         line_count,
  output logic [lrs_pkg::STAT_W-1:0]         read_count,
  output logic [lrs_pkg::STAT_W-1:0]         sent_bytes,
  output logic [lrs_pkg::LEN_W-1:0]          min_free
);

  lrs_pkg::state_t state, state_next;

  // Latched transaction
  logic [lrs_pkg::CMD_W-1:0]     cmd,      cmd_next;
  logic [lrs_pkg::BYTE_W-1:0]    in_byte,  in_byte_next;
  logic [lrs_pkg::MAX_LEN_W-1:0] want,     want_next;

  // Ring and statistics state
  logic [lrs_pkg::PTR_W-1:0]  write_ptr,  write_ptr_next;
  logic [lrs_pkg::PTR_W-1:0]  read_ptr,   read_ptr_next;
  logic [lrs_pkg::LEN_W-1:0]  line_len,   line_len_next;
  logic [lrs_pkg::STAT_W-1:0] overflows,  overflows_next;
  logic [lrs_pkg::STAT_W-1:0] lines,      lines_next;
  logic [lrs_pkg::STAT_W-1:0] bursts,     bursts_next;
  logic [lrs_pkg::STAT_W-1:0] drained,    drained_next;
  logic [lrs_pkg::LEN_W-1:0]  free_mark,  free_mark_next;

  // Working registers of the sequencer
  logic [lrs_pkg::PTR_W-1:0]  room,   room_next;
  logic [lrs_pkg::PTR_W-1:0]  avail,  avail_next;
  logic [lrs_pkg::CNT_W-1:0]  cnt,    cnt_next;
  logic                       again,  again_next;

  // Shared unit and RAM ports
  lrs_pkg::alu_req_t            alu_req;
  lrs_pkg::alu_rsp_t            alu_rsp;
  logic                         ram_we;
  logic [lrs_pkg::BYTE_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [lrs_pkg::BYTE_W-1:0]   ram_rdata;

  logic                         keep_byte;
  logic [lrs_pkg::MAX_LEN_W-1:0] want_cap;
  logic [lrs_pkg::CNT_W-1:0]    burst_n;

  lrs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  lrs_ram #(
    .DATA_W (lrs_pkg::BYTE_W),
    .DEPTH  (lrs_pkg::DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_ptr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (read_ptr),
    .rdata (ram_rdata)
  );

  // Byte is stored when nonzero and the line is still within the ring size
  assign keep_byte = (in_byte != lrs_pkg::NUL_BYTE) && (line_len < lrs_pkg::DEPTH_LEN);

  // Clamp the requested burst length and size the burst against the fill
  always_comb begin
    want_cap = (want > lrs_pkg::BURST_CAP) ? lrs_pkg::BURST_CAP : want;
    burst_n  = alu_rsp.lt ? lrs_pkg::CNT_W'(want_cap) : lrs_pkg::CNT_W'(avail);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, datapath controls and shared-unit requests
  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    in_byte_next   = in_byte;
    want_next      = want;
    write_ptr_next = write_ptr;
    read_ptr_next  = read_ptr;
    line_len_next  = line_len;
    overflows_next = overflows;
    lines_next     = lines;
    bursts_next    = bursts;
    drained_next   = drained;
    free_mark_next = free_mark;
    room_next      = room;
    avail_next     = avail;
    cnt_next       = cnt;
    again_next     = again;
    alu_req        = '0;
    ram_we         = 1'b0;
    ram_wdata      = in_byte;
    ram_re         = 1'b0;

    unique case (state)
      lrs_pkg::S_IDLE: begin
        if (start) begin
          cmd_next     = command;
          in_byte_next = line_byte;
          want_next    = max_len;
          again_next   = 1'b0;
          unique case (command)
            lrs_pkg::CMD_WRITE:    state_next = lrs_pkg::S_WRITE;
            lrs_pkg::CMD_END_LINE: state_next = lrs_pkg::S_END_PUT;
            lrs_pkg::CMD_READ:     state_next = lrs_pkg::S_RD_AVAIL;
            default:               state_next = lrs_pkg::S_STATUS;
          endcase
        end
      end

      // Store a kept line byte, count an overflow when the writer hits the reader
      lrs_pkg::S_WRITE: begin
        alu_req.a = overflows;
        alu_req.b = lrs_pkg::STAT_ONE;
        if (keep_byte) begin
          ram_we         = 1'b1;
          write_ptr_next = lrs_pkg::ptr_advance(write_ptr);
          line_len_next  = line_len + lrs_pkg::LEN_ONE;
          if ((line_len != '0) && (write_ptr == read_ptr)) begin
            overflows_next = alu_rsp.res;
          end
        end
        state_next = lrs_pkg::S_STATUS;
      end

      // Append the newline and count the line
      lrs_pkg::S_END_PUT: begin
        ram_we         = 1'b1;
        ram_wdata      = lrs_pkg::NEWLINE_BYTE;
        write_ptr_next = lrs_pkg::ptr_advance(write_ptr);
        line_len_next  = '0;
        alu_req.a      = lines;
        alu_req.b      = lrs_pkg::STAT_ONE;
        lines_next     = alu_rsp.res;
        state_next     = lrs_pkg::S_END_ROOM;
      end

      // Free space is the reader-to-writer distance, zero when they meet
      lrs_pkg::S_END_ROOM: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {{(lrs_pkg::STAT_W - lrs_pkg::PTR_W){1'b0}}, read_ptr};
        alu_req.b   = {{(lrs_pkg::STAT_W - lrs_pkg::PTR_W){1'b0}}, write_ptr};
        room_next   = alu_rsp.res[lrs_pkg::PTR_W-1:0];
        state_next  = lrs_pkg::S_END_MARK;
      end

      // Lower the free-space watermark
      lrs_pkg::S_END_MARK: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {{(lrs_pkg::STAT_W - lrs_pkg::PTR_W){1'b0}}, room};
        alu_req.b   = {{(lrs_pkg::STAT_W - lrs_pkg::LEN_W){1'b0}}, free_mark};
        if (alu_rsp.lt) begin
          free_mark_next = {1'b0, room};
        end
        state_next = lrs_pkg::S_STATUS;
      end

      // Bytes waiting in the ring
      lrs_pkg::S_RD_AVAIL: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {{(lrs_pkg::STAT_W - lrs_pkg::PTR_W){1'b0}}, write_ptr};
        alu_req.b   = {{(lrs_pkg::STAT_W - lrs_pkg::PTR_W){1'b0}}, read_ptr};
        avail_next  = alu_rsp.res[lrs_pkg::PTR_W-1:0];
        state_next  = lrs_pkg::S_RD_SIZE;
      end

      // Burst length is the smaller of the clamped request and the fill
      lrs_pkg::S_RD_SIZE: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {{(lrs_pkg::STAT_W - lrs_pkg::MAX_LEN_W){1'b0}}, want_cap};
        alu_req.b   = {{(lrs_pkg::STAT_W - lrs_pkg::PTR_W){1'b0}}, avail};
        cnt_next    = burst_n;
        if (burst_n == '0) begin
          again_next = 1'b1;
          state_next = lrs_pkg::S_STATUS;
        end else begin
          state_next = lrs_pkg::S_RD_BYTES;
        end
      end

      // Add the burst to the drained byte count
      lrs_pkg::S_RD_BYTES: begin
        alu_req.a    = drained;
        alu_req.b    = {{(lrs_pkg::STAT_W - lrs_pkg::CNT_W){1'b0}}, cnt};
        drained_next = alu_rsp.res;
        state_next   = lrs_pkg::S_RD_BURST;
      end

      // Count the burst and fetch its first byte
      lrs_pkg::S_RD_BURST: begin
        alu_req.a     = bursts;
        alu_req.b     = lrs_pkg::STAT_ONE;
        bursts_next   = alu_rsp.res;
        ram_re        = 1'b1;
        read_ptr_next = lrs_pkg::ptr_advance(read_ptr);
        state_next    = lrs_pkg::S_RD_OUT;
      end

      // Show one byte per cycle, fetching the next one behind it
      lrs_pkg::S_RD_OUT: begin
        cnt_next = cnt - lrs_pkg::CNT_ONE;
        if (cnt == lrs_pkg::CNT_ONE) begin
          state_next = lrs_pkg::S_IDLE;
        end else begin
          ram_re        = 1'b1;
          read_ptr_next = lrs_pkg::ptr_advance(read_ptr);
        end
      end

      lrs_pkg::S_STATUS: begin
        state_next = lrs_pkg::S_IDLE;
      end

      default: begin
        state_next = lrs_pkg::S_IDLE;
      end
    endcase
  end

  // Ring pointers and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      line_len  <= '0;
      overflows <= '0;
      lines     <= '0;
      bursts    <= '0;
      drained   <= '0;
      free_mark <= lrs_pkg::DEPTH_LEN;
      cnt       <= '0;
      again     <= 1'b0;
    end else begin
      write_ptr <= write_ptr_next;
      read_ptr  <= read_ptr_next;
      line_len  <= line_len_next;
      overflows <= overflows_next;
      lines     <= lines_next;
      bursts    <= bursts_next;
      drained   <= drained_next;
      free_mark <= free_mark_next;
      cnt       <= cnt_next;
      again     <= again_next;
    end
  end

  // Transaction payload and working values
  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    in_byte <= in_byte_next;
    want    <= want_next;
    room    <= room_next;
    avail   <= avail_next;
  end

  // Result ports
  always_comb begin
    busy           = (state != lrs_pkg::S_IDLE);
    done           = (state == lrs_pkg::S_STATUS) || (state == lrs_pkg::S_RD_OUT);
    byte_valid     = (state == lrs_pkg::S_RD_OUT);
    out_byte       = byte_valid ? ram_rdata : lrs_pkg::NUL_BYTE;
    last           = (state == lrs_pkg::S_STATUS) ||
                     ((state == lrs_pkg::S_RD_OUT) && (cnt == lrs_pkg::CNT_ONE));
    try_again      = (state == lrs_pkg::S_STATUS) && again;
    overflow_count = overflows;
    line_count     = lines;
    read_count     = bursts;
    sent_bytes     = drained;
    min_free       = free_mark;
  end

  // The latched command is kept only for the assertion checks below
  logic cmd_is_read;
  assign cmd_is_read = (cmd == lrs_pkg::CMD_READ);

  // A drained byte belongs to a read transaction
  assert property (@(posedge clk) disable iff (rst)
    byte_valid |-> cmd_is_read)
    else $error("byte shown outside a read transaction");

  // The last result of a transaction frees the block
  assert property (@(posedge clk) disable iff (rst)
    (done && last) |=> !busy)
    else $error("still busy after the last result");

  // An accepted transaction makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

  // A retry answer never carries a byte
  assert property (@(posedge clk) disable iff (rst)
    try_again |-> (done && last && !byte_valid))
    else $error("retry answer carries a byte or is not final");

  // Reading stops at the writer
  assert property (@(posedge clk) disable iff (rst)
    (state == lrs_pkg::S_RD_OUT && cnt != lrs_pkg::CNT_ONE) |-> (read_ptr != write_ptr))
    else $error("burst runs past the write pointer");

endmodule

### dv/line_ring_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_ring_checker: scoreboard for the line ring with overflow statistics
// Watches the command and result channels, predicts every result of each
// accepted transaction from its own copy of the ring and the counters, and
// compares results in order, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module line_ring_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              done,
  input  logic [lrs_pkg::CMD_W-1:0]         command,
  input  logic [lrs_pkg::BYTE_W-1:0]        line_byte,
  input  logic [lrs_pkg::MAX_LEN_W-1:0]     max_len,
  input  logic [lrs_pkg::BYTE_W-1:0]        out_byte,
  input  logic                              byte_valid,
  input  logic                              last,
  input  logic                              try_again,
  input  logic [lrs_pkg::STAT_W-1:0]        overflow_count,
  input  logic [lrs_pkg::STAT_W-1:0]        line_count,
  input  logic [lrs_pkg::STAT_W-1:0]        read_count,
  input  logic [lrs_pkg::STAT_W-1:0]        sent_bytes,
  input  logic [lrs_pkg::LEN_W-1:0]         min_free,
  output int                                fail_count,
  output int                                outstanding
);
  import lrs_pkg::*;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              fin;
    logic              again;
    logic [STAT_W-1:0] overflows;
    logic [STAT_W-1:0] lines;
    logic [STAT_W-1:0] bursts;
    logic [STAT_W-1:0] drained;
    logic [LEN_W-1:0]  free_floor;
  } ring_result_t;

  ring_result_t pending_results [$];

  // Predicted ring contents, pointers and statistics
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  wr_idx;
  logic [PTR_W-1:0]  rd_idx;
  int                cur_line_len;
  logic [STAT_W-1:0] overflow_total;
  logic [STAT_W-1:0] lines_total;
  logic [STAT_W-1:0] bursts_total;
  logic [STAT_W-1:0] drained_total;
  int                free_floor;

  // Queue one result carrying the statistics as they stand now
  task automatic push_result(input logic [BYTE_W-1:0] data, input logic valid,
                             input logic fin, input logic again);
    ring_result_t r;
    r.data       = data;
    r.valid      = valid;
    r.fin        = fin;
    r.again      = again;
    r.overflows  = overflow_total;
    r.lines      = lines_total;
    r.bursts     = bursts_total;
    r.drained    = drained_total;
    r.free_floor = LEN_W'(free_floor);
    pending_results.push_back(r);
  endtask

  // Apply one transaction to the predicted ring and queue its results
  task automatic predict_transaction(input logic [CMD_W-1:0] cmd,
                                     input logic [BYTE_W-1:0] b,
                                     input logic [MAX_LEN_W-1:0] len);
    logic [BYTE_W-1:0] burst_bytes [$];
    int                want;
    int                used;
    case (cmd)
      CMD_WRITE: begin
        // Keep at most DEPTH bytes per line; a later byte landing on the
        // read pointer means the writer has lapped the reader
        if (b != NUL_BYTE && cur_line_len < DEPTH) begin
          if (cur_line_len > 0 && wr_idx == rd_idx) overflow_total++;
          ring_mem[wr_idx] = b;
          wr_idx++;
          cur_line_len++;
        end
        push_result(NUL_BYTE, 1'b0, 1'b1, 1'b0);
      end
      CMD_END_LINE: begin
        ring_mem[wr_idx] = NEWLINE_BYTE;
        wr_idx++;
        cur_line_len = 0;
        // Equal pointers after a line end count as a full ring
        if (rd_idx < wr_idx) used = int'(wr_idx) - int'(rd_idx);
        else used = DEPTH - int'(rd_idx) + int'(wr_idx);
        if (DEPTH - used < free_floor) free_floor = DEPTH - used;
        lines_total++;
        push_result(NUL_BYTE, 1'b0, 1'b1, 1'b0);
      end
      CMD_READ: begin
        want = (int'(len) > MAX_BURST) ? MAX_BURST : int'(len);
        while (burst_bytes.size() < want && rd_idx != wr_idx) begin
          burst_bytes.push_back(ring_mem[rd_idx]);
          rd_idx++;
        end
        if (burst_bytes.size() == 0) begin
          push_result(NUL_BYTE, 1'b0, 1'b1, 1'b1);
        end else begin
          bursts_total++;
          drained_total += STAT_W'(burst_bytes.size());
          foreach (burst_bytes[i])
            push_result(burst_bytes[i], 1'b1, i == burst_bytes.size() - 1, 1'b0);
        end
      end
      default: begin
        push_result(NUL_BYTE, 1'b0, 1'b1, 1'b0);
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Compare the result on the ports with the oldest prediction
  task automatic check_result();
    ring_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual out_byte %0h last %0b",
               $time, out_byte, last);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("out_byte", want.data, out_byte);
      check_field("byte_valid", want.valid, byte_valid);
      check_field("last", want.fin, last);
      check_field("try_again", want.again, try_again);
      check_field("overflow_count", want.overflows, overflow_count);
      check_field("line_count", want.lines, line_count);
      check_field("read_count", want.bursts, read_count);
      check_field("sent_bytes", want.drained, sent_bytes);
      check_field("min_free", want.free_floor, min_free);
    end
  endtask

  // Results first: one shown at an edge always belongs to an earlier transaction
  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      wr_idx         = '0;
      rd_idx         = '0;
      cur_line_len   = 0;
      overflow_total = '0;
      lines_total    = '0;
      bursts_total   = '0;
      drained_total  = '0;
      free_floor     = DEPTH;
      fail_count     = 0;
    end else begin
      if (done) check_result();
      if (start && !busy) predict_transaction(command, line_byte, max_len);
    end
    outstanding <= pending_results.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level test for the line ring with overflow statistics
// Drives directed and random line, end-line, read and spare transactions,
// including lines long enough to lap the reader and to be cut at the ring
// size, while the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import lrs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int RUN_LIMIT = 400000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic                 done;
  logic [CMD_W-1:0]     command;
  logic [BYTE_W-1:0]    line_byte;
  logic [MAX_LEN_W-1:0] max_len;
  logic [BYTE_W-1:0]    out_byte;
  logic                 byte_valid;
  logic                 last;
  logic                 try_again;
  logic [STAT_W-1:0]    overflow_count;
  logic [STAT_W-1:0]    line_count;
  logic [STAT_W-1:0]    read_count;
  logic [STAT_W-1:0]    sent_bytes;
  logic [LEN_W-1:0]     min_free;
  int                   fail_count;
  int                   outstanding;

  int                   idle_pct;
  int                   sent_items;
  int                   cycle_count;

  line_ring_with_overflow_stats i_dut (.*);

  line_ring_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Mostly legal burst sizes, sometimes any value the field can hold
  function automatic logic [MAX_LEN_W-1:0] rand_len();
    if ($urandom_range(4) == 0) return MAX_LEN_W'($urandom_range(0, 31));
    return MAX_LEN_W'($urandom_range(1, MAX_BURST));
  endfunction

  // Idle at random, then hold start until the transaction is taken
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                       input logic [MAX_LEN_W-1:0] len);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    line_byte <= b;
    max_len   <= len;
    do @(posedge clk); while (busy);
    if (cmd != CMD_WRITE || b != NUL_BYTE) sent_items++;
  endtask

  // Send a line of random bytes, now and then a zero byte when allowed, then end it
  task automatic send_line(input int n_bytes, input bit with_nul = 1'b1);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n_bytes; i++) begin
      b = (with_nul && $urandom_range(19) == 0) ? NUL_BYTE :
          BYTE_W'($urandom_range(1, 255));
      issue(CMD_WRITE, b, rand_len());
    end
    issue(CMD_END_LINE, rand_byte(), rand_len());
  endtask

  // Hold off until every predicted result has been seen
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly whole lines and reads, with stray bytes and spare commands as noise
  task automatic random_traffic(input int n_items);
    int goal;
    int pick;
    goal = sent_items + n_items;
    while (sent_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 50) send_line($urandom_range(0, 8));
      else if (pick < 85) issue(CMD_READ, rand_byte(), rand_len());
      else if (pick < 93) issue(CMD_WRITE, rand_byte(), rand_len());
      else issue(CMD_SPARE, rand_byte(), rand_len());
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    command   = CMD_WRITE;
    line_byte = NUL_BYTE;
    max_len   = '0;
    idle_pct  = 27;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, spare command, field extremes, burst cut and zero
    // burst, then a second byte of a line landing on the read pointer
    issue(CMD_READ, NUL_BYTE, 5'd16);
    issue(CMD_SPARE, 8'hFF, 5'd31);
    issue(CMD_WRITE, 8'h01, 5'd0);
    issue(CMD_WRITE, 8'hFF, 5'd31);
    issue(CMD_WRITE, NUL_BYTE, 5'd16);
    issue(CMD_WRITE, 8'h80, 5'd1);
    issue(CMD_END_LINE, NUL_BYTE, 5'd0);
    issue(CMD_READ, 8'hFF, 5'd0);
    issue(CMD_READ, NUL_BYTE, 5'd31);
    issue(CMD_READ, NUL_BYTE, 5'd1);
    issue(CMD_WRITE, 8'h7F, 5'd2);
    issue(CMD_WRITE, 8'h40, 5'd4);
    issue(CMD_WRITE, NEWLINE_BYTE, 5'd8);
    issue(CMD_END_LINE, 8'hFF, 5'd31);
    issue(CMD_READ, NUL_BYTE, 5'd1);
    issue(CMD_READ, NUL_BYTE, 5'd17);
    issue(CMD_WRITE, 8'h11, 5'd0);
    issue(CMD_READ, NUL_BYTE, 5'd1);
    issue(CMD_WRITE, 8'h22, 5'd0);
    issue(CMD_END_LINE, NUL_BYTE, 5'd0);
    issue(CMD_READ, NUL_BYTE, 5'd16);

    random_traffic(70);
    wait_drained();

    idle_pct = 71;
    random_traffic(70);
    wait_drained();

    idle_pct = 0;
    // Empty the ring, then fill it exactly so the free space drops to zero
    repeat (DEPTH / MAX_BURST) issue(CMD_READ, rand_byte(), 5'd16);
    send_line(3, 1'b0);
    send_line(DEPTH - 5, 1'b0);
    // Lap the reader mid-line and run past the per-line limit
    send_line(2, 1'b0);
    send_line(DEPTH + 6, 1'b0);
    repeat (DEPTH / MAX_BURST + 6) issue(CMD_READ, rand_byte(), rand_len());
    random_traffic(70);

    wait_drained();
    repeat (24) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
